[rtl/core/vsol_pkg.sv]
// shared types, codes and constants of the voxel store with occupancy list
package vsol_pkg;

	// default grid dimensions
	localparam int AXIS_MAX_DEF    = 64;
	localparam int GRID_VOXELS_DEF = 262144;

	// fixed field widths
	localparam int EXT_W    = 7;
	localparam int CRD_W    = 8;
	localparam int VAL_W    = 8;
	localparam int CFG_IDX_W = 2;

	// flat index arithmetic widths
	localparam int HW_W   = 2 * EXT_W;
	localparam int HWZ_W  = 3 * EXT_W;
	localparam int WYX_W  = HW_W + 1;
	localparam int FLAT_W = HWZ_W + 1;

	// extent register reset value
	localparam logic [EXT_W-1:0] EXT_RESET = 7'd64;

	// request opcodes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_GRID_DEPTH  = 2'd2
	} cfg_reg_t;

	// result status codes
	typedef enum logic [2:0] {
		STATUS_OOB     = 3'd0,
		STATUS_SAME    = 3'd1,
		STATUS_CHANGED = 3'd2,
		STATUS_ADDED   = 3'd3,
		STATUS_REMOVED = 3'd4
	} status_t;

endpackage

[rtl/core/vsol_ram.sv]
// generic simple dual-port ram with one write port and a registered read port
module vsol_ram #(
	parameter int WIDTH = vsol_pkg::VAL_W,
	parameter int DEPTH = vsol_pkg::GRID_VOXELS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/voxel_store_occupancy_list.sv]
// top level: voxel store with dense occupancy list and swap-remove
//
// After reset the block runs a clearing pass over the voxel memory, one entry per
// cycle; requests are not taken during that pass, configuration writes are. A
// read, an out-of-bounds access, a value change, an append or a removal of the
// last list entry passes through the steps index multiply, index add with voxel
// memory read, decide and write back, and result; the next request can enter at
// the result step once the output register is free. A removal that moves the
// last list entry into the freed slot also reads the list memory, makes a second
// pass through the flat index multiplier and, when the moved voxel's map entry is
// rewritten, a voxel memory read-modify-write.
// The result register is separate, so the next request is taken while a result
// still waits on out_ready.
module voxel_store_occupancy_list #(
	parameter int AXIS_MAX    = vsol_pkg::AXIS_MAX_DEF,
	parameter int GRID_VOXELS = vsol_pkg::GRID_VOXELS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// request channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    op,
	input  logic signed [vsol_pkg::CRD_W-1:0]       coord_x,
	input  logic signed [vsol_pkg::CRD_W-1:0]       coord_y,
	input  logic signed [vsol_pkg::CRD_W-1:0]       coord_z,
	input  logic [vsol_pkg::VAL_W-1:0]              write_value,
	// result channel
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [2:0]                              status,
	output logic [vsol_pkg::VAL_W-1:0]              prior_value,
	output logic                                    slot_update_valid,
	output logic [$clog2(GRID_VOXELS)-1:0]          slot_index,
	output logic [$clog2(AXIS_MAX)-1:0]             slot_x,
	output logic [$clog2(AXIS_MAX)-1:0]             slot_y,
	output logic [$clog2(AXIS_MAX)-1:0]             slot_z,
	output logic [$clog2(GRID_VOXELS+1)-1:0]        occupied_total,
	// configuration channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [vsol_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vsol_pkg::EXT_W-1:0]              cfg_data
);

	import vsol_pkg::*;

	localparam int CW = $clog2(AXIS_MAX);
	localparam int SW = $clog2(GRID_VOXELS);
	localparam int NW = $clog2(GRID_VOXELS + 1);
	localparam int VW = VAL_W + 1 + SW;
	localparam int LW = 3 * CW;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_SUM   = 8'b0000_1000,
		ST_VRD   = 8'b0001_0000,
		ST_LRD   = 8'b0010_0000,
		ST_MRD   = 8'b0100_0000,
		ST_RES   = 8'b1000_0000
	} state_t;

	// clip an extent register to the axis limit
	function automatic logic [EXT_W-1:0] clip_ext(input logic [EXT_W-1:0] r);
		logic [EXT_W-1:0] e;
		e = (32'(r) > 32'(AXIS_MAX)) ? EXT_W'(AXIS_MAX) : r;
		return e;
	endfunction

	// control state
	state_t           state_q;
	logic [SW-1:0]    clr_q;
	logic [NW-1:0]    count_q;
	logic [EXT_W-1:0] cfg_w_q, cfg_h_q, cfg_d_q;
	logic             out_valid_q;

	// working registers
	logic             op_q;
	logic [VAL_W-1:0] nv_q;
	logic [CW-1:0]    px_q, py_q, pz_q;
	logic             okc_q;
	logic             mv_q;
	logic [HW_W-1:0]  hw_q;
	logic [HW_W-1:0]  wy_q;
	logic [HWZ_W-1:0] hwz_q;
	logic [WYX_W-1:0] wyx_q;
	logic [SW-1:0]    flat_q;
	logic             inb_q;
	logic [SW-1:0]    s_q;

	// result being built and the output register
	status_t          res_status_q;
	logic [VAL_W-1:0] res_old_q;
	logic             res_sv_q;
	logic [SW-1:0]    res_si_q;
	logic [CW-1:0]    res_sx_q, res_sy_q, res_sz_q;
	logic [2:0]       out_status_q;
	logic [VAL_W-1:0] out_old_q;
	logic             out_sv_q;
	logic [SW-1:0]    out_si_q;
	logic [CW-1:0]    out_sx_q, out_sy_q, out_sz_q;
	logic [NW-1:0]    out_total_q;

	// memory ports
	logic             vox_we;
	logic [SW-1:0]    vox_waddr;
	logic [VW-1:0]    vox_wdata;
	logic [SW-1:0]    vox_raddr;
	logic [VW-1:0]    vox_rdata;
	logic             lst_we;
	logic [SW-1:0]    lst_waddr;
	logic [LW-1:0]    lst_wdata;
	logic [SW-1:0]    lst_raddr;
	logic [LW-1:0]    lst_rdata;

	// combinational helpers
	logic [EXT_W-1:0]  ew, eh, ed;
	logic              in_acc, out_free;
	logic              in_ok, m_ok;
	logic [CW-1:0]     m_x, m_y, m_z;
	logic [EXT_W-1:0]  y_src;
	logic [HW_W-1:0]   mul_wy;
	logic [FLAT_W-1:0] flat_sum;
	logic              in_grid, same_flat;
	logic [VAL_W-1:0]  v_old;
	logic              v_held;
	logic [SW-1:0]     v_slot;
	logic              v_wr, v_add, v_rem, room, slot_ok, slot_last;
	logic [NW-1:0]     cnt_dec;
	status_t           vrd_status;

	// extents in use
	assign ew = clip_ext(cfg_w_q);
	assign eh = clip_ext(cfg_h_q);
	assign ed = clip_ext(cfg_d_q);

	// handshakes
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_RES) && out_free);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// bounds of the request coordinates
	assign in_ok = !coord_x[CRD_W-1] && !coord_y[CRD_W-1] && !coord_z[CRD_W-1] &&
	               (coord_x[EXT_W-1:0] < ew) && (coord_y[EXT_W-1:0] < eh) &&
	               (coord_z[EXT_W-1:0] < ed);

	// moved list entry and its bounds
	assign m_x  = lst_rdata[LW-1 -: CW];
	assign m_y  = lst_rdata[2*CW-1 -: CW];
	assign m_z  = lst_rdata[CW-1:0];
	assign m_ok = (32'(m_x) < 32'(ew)) && (32'(m_y) < 32'(eh)) && (32'(m_z) < 32'(ed));

	// shared width-times-y multiplier
	assign y_src  = (state_q == ST_LRD) ? EXT_W'(m_y) : coord_y[EXT_W-1:0];
	assign mul_wy = HW_W'(ew) * HW_W'(y_src);

	// flat index sum and grid check
	assign flat_sum  = FLAT_W'(hwz_q) + FLAT_W'(wyx_q);
	assign in_grid   = okc_q && (32'(flat_sum) < 32'(GRID_VOXELS));
	assign same_flat = (SW'(flat_sum) == flat_q);

	// decode of the voxel entry read back
	assign v_old     = vox_rdata[VW-1 -: VAL_W];
	assign v_held    = vox_rdata[SW];
	assign v_slot    = vox_rdata[SW-1:0];
	assign v_wr      = inb_q && (op_q == OP_WRITE) && (v_old != nv_q);
	assign v_add     = v_wr && (v_old == '0) && (nv_q != '0);
	assign v_rem     = v_wr && (v_old != '0) && (nv_q == '0);
	assign room      = count_q < NW'(GRID_VOXELS);
	assign cnt_dec   = count_q - NW'(1);
	assign slot_ok   = v_held && (NW'(v_slot) < count_q);
	assign slot_last = (NW'(v_slot) == cnt_dec);

	// status of the request
	always_comb begin
		if (!inb_q) begin
			vrd_status = STATUS_OOB;
		end else if (!v_wr) begin
			vrd_status = STATUS_SAME;
		end else if ((v_old != '0) == (nv_q != '0)) begin
			vrd_status = STATUS_CHANGED;
		end else if (v_add) begin
			vrd_status = STATUS_ADDED;
		end else begin
			vrd_status = STATUS_REMOVED;
		end
	end

	// memory addresses and write data
	assign vox_raddr = SW'(flat_sum);
	assign lst_raddr = SW'(cnt_dec);

	always_comb begin
		vox_we    = 1'b0;
		vox_waddr = flat_q;
		vox_wdata = {nv_q, v_held, v_slot};
		lst_we    = 1'b0;
		lst_waddr = s_q;
		lst_wdata = lst_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				vox_we    = 1'b1;
				vox_waddr = clr_q;
				vox_wdata = '0;
			end
			ST_VRD: begin
				vox_we = v_wr;
				if (v_add && room) begin
					vox_wdata = {nv_q, 1'b1, SW'(count_q)};
					lst_we    = 1'b1;
					lst_waddr = SW'(count_q);
					lst_wdata = {px_q, py_q, pz_q};
				end else if (v_rem && slot_ok) begin
					vox_wdata = '0;
				end
			end
			ST_LRD: begin
				lst_we = 1'b1;
			end
			ST_MRD: begin
				vox_we    = 1'b1;
				vox_wdata = {v_old, 1'b1, s_q};
			end
			default: begin
			end
		endcase
	end

	// control registers and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			cfg_w_q     <= EXT_RESET;
			cfg_h_q     <= EXT_RESET;
			cfg_d_q     <= EXT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  cfg_w_q <= cfg_data;
					REG_GRID_HEIGHT: cfg_h_q <= cfg_data;
					REG_GRID_DEPTH:  cfg_d_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// result register fill and drain
			if ((state_q == ST_RES) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(GRID_VOXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!mv_q) begin
						state_q <= ST_VRD;
					end else if (in_grid && !same_flat) begin
						state_q <= ST_MRD;
					end else begin
						state_q <= ST_RES;
					end
				end
				ST_VRD: begin
					if (v_add && room) begin
						count_q <= count_q + NW'(1);
					end
					if (v_rem && slot_ok) begin
						count_q <= cnt_dec;
					end
					if (v_rem && slot_ok && !slot_last) begin
						state_q <= ST_LRD;
					end else begin
						state_q <= ST_RES;
					end
				end
				ST_LRD: begin
					state_q <= ST_MUL;
				end
				ST_MRD: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						state_q <= in_acc ? ST_MUL : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// request capture, width products and bounds
		if (in_acc) begin
			op_q  <= op;
			nv_q  <= write_value;
			px_q  <= CW'(coord_x[EXT_W-1:0]);
			py_q  <= CW'(coord_y[EXT_W-1:0]);
			pz_q  <= CW'(coord_z[EXT_W-1:0]);
			okc_q <= in_ok;
			hw_q  <= HW_W'(eh) * HW_W'(ew);
			wy_q  <= mul_wy;
			mv_q  <= 1'b0;
		end
		unique case (state_q)
			ST_MUL: begin
				hwz_q <= HWZ_W'(hw_q) * HWZ_W'(EXT_W'(pz_q));
				wyx_q <= WYX_W'(wy_q) + WYX_W'(EXT_W'(px_q));
			end
			ST_SUM: begin
				flat_q <= SW'(flat_sum);
				inb_q  <= in_grid;
			end
			ST_VRD: begin
				res_status_q <= vrd_status;
				res_old_q    <= inb_q ? v_old : '0;
				res_sv_q     <= v_add && room;
				res_si_q     <= (v_add && room) ? SW'(count_q) : '0;
				res_sx_q     <= (v_add && room) ? px_q : '0;
				res_sy_q     <= (v_add && room) ? py_q : '0;
				res_sz_q     <= (v_add && room) ? pz_q : '0;
				s_q          <= v_slot;
			end
			ST_LRD: begin
				// moved entry fills the freed slot, then its map entry is located
				res_sv_q <= 1'b1;
				res_si_q <= s_q;
				res_sx_q <= m_x;
				res_sy_q <= m_y;
				res_sz_q <= m_z;
				px_q     <= m_x;
				py_q     <= m_y;
				pz_q     <= m_z;
				okc_q    <= m_ok;
				wy_q     <= mul_wy;
				mv_q     <= 1'b1;
			end
			ST_RES: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_old_q    <= res_old_q;
					out_sv_q     <= res_sv_q;
					out_si_q     <= res_si_q;
					out_sx_q     <= res_sx_q;
					out_sy_q     <= res_sy_q;
					out_sz_q     <= res_sz_q;
					out_total_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	// voxel value and slot map memory
	vsol_ram #(
		.WIDTH (VW),
		.DEPTH (GRID_VOXELS)
	) u_vox_ram (
		.clk   (clk),
		.we    (vox_we),
		.waddr (vox_waddr),
		.wdata (vox_wdata),
		.raddr (vox_raddr),
		.rdata (vox_rdata)
	);

	// dense occupancy list memory
	vsol_ram #(
		.WIDTH (LW),
		.DEPTH (GRID_VOXELS)
	) u_lst_ram (
		.clk   (clk),
		.we    (lst_we),
		.waddr (lst_waddr),
		.wdata (lst_wdata),
		.raddr (lst_raddr),
		.rdata (lst_rdata)
	);

	// result ports
	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign prior_value       = out_old_q;
	assign slot_update_valid = out_sv_q;
	assign slot_index        = out_si_q;
	assign slot_x            = out_sx_q;
	assign slot_y            = out_sy_q;
	assign slot_z            = out_sz_q;
	assign occupied_total    = out_total_q;

endmodule

[tb/tb_voxel_store_occupancy_list.sv]
// self-checking testbench for the voxel store with dense occupancy list
module tb_voxel_store_occupancy_list;
	import vsol_pkg::*;

	localparam int AXIS_MAX      = AXIS_MAX_DEF;
	localparam int GRID_VOXELS   = GRID_VOXELS_DEF;
	localparam int SLOT_W        = $clog2(GRID_VOXELS);
	localparam int AXIS_W        = $clog2(AXIS_MAX);
	localparam int COUNT_W       = $clog2(GRID_VOXELS + 1);
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int MAX_GAP       = 6;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 90;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		status_t              status;
		logic [VAL_W-1:0]     prior_value;
		logic                 slot_update_valid;
		logic [SLOT_W-1:0]    slot_index;
		logic [AXIS_W-1:0]    slot_x;
		logic [AXIS_W-1:0]    slot_y;
		logic [AXIS_W-1:0]    slot_z;
		logic [COUNT_W-1:0]   occupied_total;
	} access_result_t;

	// block ports
	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     op          = OP_READ;
	logic signed [CRD_W-1:0]  coord_x     = '0;
	logic signed [CRD_W-1:0]  coord_y     = '0;
	logic signed [CRD_W-1:0]  coord_z     = '0;
	logic [VAL_W-1:0]         write_value = '0;
	logic                     out_ready   = 1'b0;
	logic                     cfg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index   = '0;
	logic [EXT_W-1:0]         cfg_data    = '0;
	logic                     cfg_ready;
	logic                     in_ready;
	logic                     out_valid;
	logic [2:0]               status;
	logic [VAL_W-1:0]         prior_value;
	logic                     slot_update_valid;
	logic [SLOT_W-1:0]        slot_index;
	logic [AXIS_W-1:0]        slot_x;
	logic [AXIS_W-1:0]        slot_y;
	logic [AXIS_W-1:0]        slot_z;
	logic [COUNT_W-1:0]       occupied_total;

	// mirrored grid, map and list contents
	bit [VAL_W-1:0]           voxel_mem [GRID_VOXELS];
	bit [SLOT_W-1:0]          slot_map  [GRID_VOXELS];
	bit                       slot_held [GRID_VOXELS];
	bit [AXIS_W-1:0]          list_x    [GRID_VOXELS];
	bit [AXIS_W-1:0]          list_y    [GRID_VOXELS];
	bit [AXIS_W-1:0]          list_z    [GRID_VOXELS];
	int                       occ_count = 0;
	int                       grid_w    = int'(EXT_RESET);
	int                       grid_h    = int'(EXT_RESET);
	int                       grid_d    = int'(EXT_RESET);

	access_result_t           pending_results [$];
	access_result_t           due;
	bit                       req_held       = 1'b0;
	bit                       no_idle        = 1'b0;
	int                       ready_hold     = 0;
	int                       mismatch_count = 0;
	int                       result_count   = 0;
	int                       cycle_count    = 0;

	voxel_store_occupancy_list DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.prior_value(prior_value),
		.slot_update_valid(slot_update_valid),
		.slot_index(slot_index),
		.slot_x(slot_x),
		.slot_y(slot_y),
		.slot_z(slot_z),
		.occupied_total(occupied_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// idle cycles before a request or after a result
	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// extent register as used by the block
	function automatic int axis_extent(input int ext_reg);
		return (ext_reg > AXIS_MAX) ? AXIS_MAX : ext_reg;
	endfunction

	// bounds check and flat index under the current extents
	function automatic bit grid_locate(input int x, input int y, input int z, output int flat);
		int w;
		int h;
		int d;
		w = axis_extent(grid_w);
		h = axis_extent(grid_h);
		d = axis_extent(grid_d);
		flat = 0;
		if (x < 0 || y < 0 || z < 0)
			return 1'b0;
		if (x >= w || y >= h || z >= d)
			return 1'b0;
		flat = h * w * z + w * y + x;
		return flat < GRID_VOXELS;
	endfunction

	// one access applied to the mirrored state, giving the result it causes
	function automatic access_result_t apply_voxel_access(input logic is_write, input int x,
			input int y, input int z, input logic [VAL_W-1:0] nv);
		access_result_t r;
		int flat;
		int moved_flat;
		int s;
		int last;
		logic [VAL_W-1:0] ov;
		r.status            = STATUS_OOB;
		r.prior_value       = '0;
		r.slot_update_valid = 1'b0;
		r.slot_index        = '0;
		r.slot_x            = '0;
		r.slot_y            = '0;
		r.slot_z            = '0;
		if (grid_locate(x, y, z, flat)) begin
			ov = voxel_mem[flat];
			r.prior_value = ov;
			if (is_write != OP_WRITE || ov == nv) begin
				r.status = STATUS_SAME;
			end else begin
				voxel_mem[flat] = nv;
				if ((ov != 0) == (nv != 0)) begin
					r.status = STATUS_CHANGED;
				end else if (nv != 0) begin
					// append unless the list is full
					r.status = STATUS_ADDED;
					if (occ_count < GRID_VOXELS) begin
						s = occ_count;
						list_x[s] = AXIS_W'(x);
						list_y[s] = AXIS_W'(y);
						list_z[s] = AXIS_W'(z);
						slot_map[flat]  = SLOT_W'(s);
						slot_held[flat] = 1'b1;
						occ_count = s + 1;
						r.slot_update_valid = 1'b1;
						r.slot_index = SLOT_W'(s);
						r.slot_x = list_x[s];
						r.slot_y = list_y[s];
						r.slot_z = list_z[s];
					end
				end else begin
					// swap-remove, only when the map holds a live slot
					r.status = STATUS_REMOVED;
					if (slot_held[flat] && int'(slot_map[flat]) < occ_count) begin
						s = int'(slot_map[flat]);
						last = occ_count - 1;
						if (s != last) begin
							list_x[s] = list_x[last];
							list_y[s] = list_y[last];
							list_z[s] = list_z[last];
							if (grid_locate(int'(list_x[s]), int'(list_y[s]),
									int'(list_z[s]), moved_flat)) begin
								slot_map[moved_flat]  = SLOT_W'(s);
								slot_held[moved_flat] = 1'b1;
							end
							r.slot_update_valid = 1'b1;
							r.slot_index = SLOT_W'(s);
							r.slot_x = list_x[s];
							r.slot_y = list_y[s];
							r.slot_z = list_z[s];
						end
						slot_held[flat] = 1'b0;
						slot_map[flat]  = '0;
						occ_count = last;
					end
				end
			end
		end
		r.occupied_total = COUNT_W'(occ_count);
		return r;
	endfunction

	// drop in_valid if a request was left standing
	task automatic release_request();
		if (req_held) begin
			in_valid <= 1'b0;
			req_held = 1'b0;
		end
	endtask

	// present one request and wait for it to be taken
	task automatic send_access(input logic is_write, input int x, input int y, input int z,
			input int value);
		int gap;
		access_result_t predicted;
		gap = draw_gap();
		if (gap > 0) begin
			release_request();
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= is_write;
		coord_x     <= CRD_W'(x);
		coord_y     <= CRD_W'(y);
		coord_z     <= CRD_W'(z);
		write_value <= VAL_W'(value);
		do @(posedge clk); while (!in_ready);
		req_held = 1'b1;
		predicted = apply_voxel_access(is_write, x, y, z, VAL_W'(value));
		pending_results = {pending_results, predicted};
	endtask

	// wait until every result is back, then let the block settle
	task automatic drain_results();
		release_request();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write on the configuration channel
	task automatic write_grid_reg(input cfg_reg_t idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= EXT_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:  grid_w = value & 'h7f;
			REG_GRID_HEIGHT: grid_h = value & 'h7f;
			REG_GRID_DEPTH:  grid_d = value & 'h7f;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_grid(input int w, input int h, input int d);
		write_grid_reg(REG_GRID_WIDTH, w);
		write_grid_reg(REG_GRID_HEIGHT, h);
		write_grid_reg(REG_GRID_DEPTH, d);
	endtask

	// coordinate mostly inside the extent, often near the origin, sometimes anywhere
	function automatic int pick_coord(input int ext_reg);
		int e;
		e = axis_extent(ext_reg);
		if (e == 0 || $urandom_range(0, 99) < 5)
			return int'($urandom_range(0, 191)) - 64;
		if (e > 4 && $urandom_range(0, 1) == 1)
			return $urandom_range(0, 3);
		return $urandom_range(0, e - 1);
	endfunction

	// value biased toward empty and the extremes
	function automatic int pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 55)
			return 255;
		if (r < 60)
			return 1;
		return $urandom_range(1, 255);
	endfunction

	// result checking and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("result %0d arrived with no request outstanding", result_count);
			end else begin
				due = pending_results.pop_front();
				if (status !== due.status || prior_value !== due.prior_value
						|| slot_update_valid !== due.slot_update_valid
						|| slot_index !== due.slot_index || slot_x !== due.slot_x
						|| slot_y !== due.slot_y || slot_z !== due.slot_z
						|| occupied_total !== due.occupied_total) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("result %0d exp: st=%0d old=%0d sv=%0d si=%0d xyz=%0d,%0d,%0d n=%0d",
							result_count, due.status, due.prior_value, due.slot_update_valid,
							due.slot_index, due.slot_x, due.slot_y, due.slot_z,
							due.occupied_total);
						$display("result %0d act: st=%0d old=%0d sv=%0d si=%0d xyz=%0d,%0d,%0d n=%0d",
							result_count, status, prior_value, slot_update_valid,
							slot_index, slot_x, slot_y, slot_z, occupied_total);
					end
				end
			end
			ready_hold = draw_gap();
		end else if (ready_hold > 0) begin
			ready_hold--;
		end
		out_ready <= (ready_hold == 0);
	end

	// registers written while the clearing pass runs
	task automatic test_config_at_reset();
		set_grid(64, 64, 64);
	endtask

	// reads, unchanged writes, appends and value changes at the corners
	task automatic test_basic_access();
		send_access(OP_READ, 0, 0, 0, 0);
		send_access(OP_WRITE, 0, 0, 0, 0);
		send_access(OP_WRITE, 63, 63, 63, 255);
		send_access(OP_WRITE, 0, 0, 0, 1);
		send_access(OP_WRITE, 63, 63, 63, 128);
		send_access(OP_READ, 63, 63, 63, 77);
	endtask

	// negative and too-large coordinates
	task automatic test_out_of_bounds();
		send_access(OP_WRITE, -1, 0, 0, 5);
		send_access(OP_WRITE, 0, -64, 0, 5);
		send_access(OP_WRITE, 0, 0, 64, 5);
		send_access(OP_WRITE, 127, 127, 127, 5);
		send_access(OP_READ, -64, -64, -64, 5);
	endtask

	// removal with the last entry moved in, then removal of the last entry itself
	task automatic test_swap_remove();
		send_access(OP_WRITE, 10, 20, 30, 7);
		send_access(OP_WRITE, 63, 63, 63, 0);
		send_access(OP_WRITE, 10, 20, 30, 0);
		send_access(OP_WRITE, 0, 0, 0, 0);
	endtask

	// moved entry outside a narrowed grid leaves a stale map entry, later a missing slot
	task automatic test_stale_slot();
		send_access(OP_WRITE, 1, 0, 0, 9);
		send_access(OP_WRITE, 40, 0, 0, 9);
		drain_results();
		write_grid_reg(REG_GRID_WIDTH, 32);
		send_access(OP_WRITE, 1, 0, 0, 0);
		drain_results();
		write_grid_reg(REG_GRID_WIDTH, 64);
		send_access(OP_WRITE, 40, 0, 0, 0);
		drain_results();
	endtask

	// zero extent blocks every access, oversize extents clamp
	task automatic test_extent_limits();
		write_grid_reg(REG_GRID_DEPTH, 0);
		send_access(OP_WRITE, 0, 0, 0, 3);
		send_access(OP_READ, 0, 0, 0, 0);
		drain_results();
		set_grid(127, 64, 127);
		send_access(OP_READ, 63, 63, 63, 0);
		send_access(OP_WRITE, 63, 0, 0, 128);
		drain_results();
	endtask

	// random traffic over several grid shapes
	task automatic test_random_mixed();
		int pw [PHASES];
		int ph [PHASES];
		int pd [PHASES];
		int p;
		int i;
		pw = '{4, 1, 2, 64, 1, 1, 8, 127, 3};
		ph = '{4, 1, 3, 1, 64, 1, 8, 127, 2};
		pd = '{4, 1, 5, 1, 1, 64, 8, 127, 4};
		for (p = 0; p < PHASES; p++) begin
			drain_results();
			set_grid(pw[p], ph[p], pd[p]);
			no_idle = (p == 6);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// pause the sender until everything is back
				if (p == 3 && i == PHASE_ITEMS / 2)
					drain_results();
				send_access(($urandom_range(0, 99) < 80) ? OP_WRITE : OP_READ,
					pick_coord(grid_w), pick_coord(grid_h), pick_coord(grid_d),
					pick_value());
			end
		end
		no_idle = 1'b0;
	endtask

	// test sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_config_at_reset();
		test_basic_access();
		test_out_of_bounds();
		test_swap_remove();
		test_stale_slot();
		test_extent_limits();
		test_random_mixed();
		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
